// ----- src/intnest_pkg.sv -----
// ----------------------------------------------------------------------------
// intnest_pkg
// Shared constants, widths and sequencer states for the interval nesting
// level tracker.
// ----------------------------------------------------------------------------
package intnest_pkg;

  // Stack sizing
  localparam int MAX_DEPTH = 32;
  localparam int NUM_TYPES = 8;

  // Field widths
  localparam int TIME_W = 48;
  localparam int END_W  = TIME_W + 1;
  localparam int ETYP_W = 3;
  localparam int OLVL_W = 6;

  // Derived widths
  localparam int SLOT_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LVL_W  = $clog2(MAX_DEPTH + 1);
  localparam int TYPE_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int TADR_W = TYPE_W + SLOT_W;

  // Stream widths
  localparam int S_DATA_W = ((2 * TIME_W + ETYP_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((2 * OLVL_W + 7) / 8) * 8;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CMP_TOP,
    ST_CMP_PAR,
    ST_WRITE
  } state_t;

endpackage

// ----- src/interval_nesting_level_tracker.sv -----
// ----------------------------------------------------------------------------
// interval_nesting_level_tracker
// Tracks nesting depth of trace intervals on a shared stack of end times and
// on one stack per interval type, walking each stack with one comparator.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one interval per beat. s_tdata carries start_time,
//   duration and event_type; s_tuser carries start_of_trace, which empties
//   all stacks before the interval is handled.
//   Master channel m_*: one result beat per interval, in order. m_tdata
//   carries overall_level and type_level; m_tuser carries depth_overflow.
//   Sequencing: a sequencer walks the shared stack, then the type stack,
//   through one end-time comparator and a registered read of each stack
//   memory; one ST_CMP_PAR step per parent compared. s_tready is high only
//   while idle, so no new interval is taken while one is being walked.
//   The result sits in an output register, so the next interval is accepted
//   while the previous result waits; a held result stalls the sequencer only
//   when the next result is ready to be loaded.
//   Reset: all stacks empty (levels 1, end times zero), no result pending.
//   Levels above the stack depth are clamped and flagged by depth_overflow.
// ----------------------------------------------------------------------------
module interval_nesting_level_tracker
  import intnest_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // s_tdata: start_time[47:0], duration[95:48], event_type[98:96], zero fill
  input  logic [S_DATA_W-1:0] s_tdata,
  // s_tuser: start_of_trace[0]
  input  logic                s_tuser,
  input  logic                s_tvalid,
  output logic                s_tready,
  // m_tdata: overall_level[5:0], type_level[11:6], zero fill
  output logic [M_DATA_W-1:0] m_tdata,
  // m_tuser: depth_overflow[0]
  output logic                m_tuser,
  output logic                m_tvalid,
  input  logic                m_tready
);

  // Sequencer
  state_t state, state_next;

  // Latched item
  logic [TIME_W-1:0] st;
  logic [END_W-1:0]  fin;
  logic [TYPE_W-1:0] ty;
  logic              ty_ok;

  // Working registers
  logic             sel;
  logic [LVL_W-1:0] lv;
  logic [LVL_W-1:0] lv_all;
  logic             ovf;

  // Stack tops and first-slot fresh marks
  logic [LVL_W-1:0] overall_top;
  logic [LVL_W-1:0] type_top [NUM_TYPES];
  logic             overall_fresh;
  logic             type_fresh [NUM_TYPES];

  // Stack memories
  logic [END_W-1:0] overall_mem [2**SLOT_W];
  logic [END_W-1:0] type_mem [2**TADR_W];
  logic [END_W-1:0] overall_rd;
  logic [END_W-1:0] type_rd;

  // Combinational helpers
  logic              in_fire;
  logic              out_free;
  logic [LVL_W-1:0]  top_sel;
  logic              fresh_sel;
  logic [LVL_W-1:0]  rd_lvl;
  logic [SLOT_W-1:0] rd_slot;
  logic [SLOT_W-1:0] wr_slot;
  logic [END_W-1:0]  cmp_val;
  logic              cmp_gt;
  logic              last_stack;
  logic              in_ty_ok;
  logic [ETYP_W-1:0] in_etype;

  assign s_tready   = (state == ST_IDLE) && !rst;
  assign in_fire    = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign in_etype   = s_tdata[2*TIME_W +: ETYP_W];
  assign in_ty_ok   = (32'(in_etype) < 32'(NUM_TYPES));
  assign top_sel    = sel ? type_top[ty] : overall_top;
  assign fresh_sel  = sel ? type_fresh[ty] : overall_fresh;
  assign last_stack = sel || !ty_ok;
  assign wr_slot    = SLOT_W'(lv - LVL_W'(1));

  // Pick the slot to read: top, parent, or the parent after one more pop
  always_comb begin
    unique case (state)
      ST_LOAD:    rd_lvl = top_sel - LVL_W'(1);
      ST_CMP_TOP: rd_lvl = lv - LVL_W'(2);
      ST_CMP_PAR: rd_lvl = lv - LVL_W'(3);
      default:    rd_lvl = '0;
    endcase
  end
  assign rd_slot = SLOT_W'(rd_lvl);

  // Shared end-time comparator; an unwritten first slot reads as zero
  assign cmp_val = (sel ? type_rd : overall_rd);
  assign cmp_gt  = ((fresh_sel && (lv == LVL_W'(1))) ? '0 : cmp_val) > END_W'(st);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_LOAD;
      end
      ST_LOAD: state_next = ST_CMP_TOP;
      ST_CMP_TOP: begin
        if (!cmp_gt && (lv > LVL_W'(1))) state_next = ST_CMP_PAR;
        else                             state_next = ST_WRITE;
      end
      ST_CMP_PAR: begin
        if (cmp_gt || (lv <= LVL_W'(2))) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (!last_stack)    state_next = ST_LOAD;
        else if (out_free)  state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Registered stack reads
  always_ff @(posedge clk) begin
    overall_rd <= overall_mem[rd_slot];
    type_rd    <= type_mem[{ty, rd_slot}];
  end

  // Stack writes
  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      if (sel) type_mem[{ty, wr_slot}] <= fin;
      else     overall_mem[wr_slot]    <= fin;
    end
  end

  // Latch the item and compute its end time
  always_ff @(posedge clk) begin
    if (in_fire) begin
      st    <= s_tdata[TIME_W-1:0];
      fin   <= END_W'(s_tdata[TIME_W-1:0]) + END_W'(s_tdata[TIME_W +: TIME_W]);
      ty    <= TYPE_W'(in_etype);
      ty_ok <= in_ty_ok;
    end
  end

  // Working level and overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      sel    <= 1'b0;
      lv     <= LVL_W'(1);
      lv_all <= LVL_W'(1);
      ovf    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            sel <= 1'b0;
            ovf <= 1'b0;
          end
        end
        ST_LOAD: lv <= top_sel;
        ST_CMP_TOP: begin
          // Push when the top interval is still open
          if (cmp_gt) begin
            if (lv < LVL_W'(MAX_DEPTH)) lv  <= lv + LVL_W'(1);
            else                        ovf <= 1'b1;
          end
        end
        ST_CMP_PAR: begin
          // Drop one level while the parent has ended
          if (!cmp_gt) lv <= lv - LVL_W'(1);
        end
        ST_WRITE: begin
          if (!sel) lv_all <= lv;
          if (!last_stack) sel <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Stack tops and fresh marks
  always_ff @(posedge clk) begin
    if (rst) begin
      overall_top   <= LVL_W'(1);
      overall_fresh <= 1'b1;
      for (int i = 0; i < NUM_TYPES; i++) begin
        type_top[i]   <= LVL_W'(1);
        type_fresh[i] <= 1'b1;
      end
    end else if (in_fire && s_tuser) begin
      overall_top   <= LVL_W'(1);
      overall_fresh <= 1'b1;
      for (int i = 0; i < NUM_TYPES; i++) begin
        type_top[i]   <= LVL_W'(1);
        type_fresh[i] <= 1'b1;
      end
    end else if (state == ST_WRITE) begin
      if (sel) begin
        type_top[ty]   <= lv;
        type_fresh[ty] <= 1'b0;
      end else begin
        overall_top   <= lv;
        overall_fresh <= 1'b0;
      end
    end
  end

  // Output register: load the finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_WRITE) && last_stack && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_WRITE) && last_stack && out_free) begin
      m_tuser <= ovf;
      if (sel) begin
        m_tdata <= M_DATA_W'({OLVL_W'(lv), OLVL_W'(lv_all)});
      end else begin
        m_tdata <= M_DATA_W'({OLVL_W'(1), OLVL_W'(lv)});
      end
    end
  end

endmodule
